/* src/tps_pkg.sv */
package tps_pkg;

  typedef enum logic [1:0] {
    ModeTick = 2'd0,
    ModeLoad = 2'd1,
    ModePlay = 2'd2,
    ModeStop = 2'd3
  } mode_e;

  localparam int unsigned StepFieldW = 4;
  localparam int unsigned RemainFieldW = 5;
  localparam int unsigned SlotFieldW = 4;
  localparam int unsigned LenFieldW = 5;

endpackage

/* src/tps_table.sv */
module tps_table #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned DUR_W = 16,
  parameter int unsigned OUT_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [DUR_W-1:0] wdur_i,
  input  logic [OUT_W-1:0] wout_i,
  input  logic [IDX_W-1:0] raddr_cur_i,
  input  logic [IDX_W-1:0] raddr_nxt_i,
  output logic [DUR_W-1:0] cur_dur_o,
  output logic [OUT_W-1:0] nxt_out_o,
  output logic [OUT_W-1:0] first_out_o
);

  localparam int unsigned Depth = 2 ** IDX_W;

  logic [DUR_W-1:0] dur_mem [Depth];
  logic [OUT_W-1:0] out_mem [Depth];

  logic [DUR_W-1:0] cur_dur_q;
  logic [OUT_W-1:0] nxt_out_q;
  logic [OUT_W-1:0] first_out_q;
  logic [DUR_W-1:0] wdur_q;
  logic [OUT_W-1:0] wout_q;
  logic             fwd_cur_q, fwd_nxt_q, fwd_first_q;
  logic             fwd_cur_d, fwd_nxt_d, fwd_first_d;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dur_mem[waddr_i] <= wdur_i;
      out_mem[waddr_i] <= wout_i;
    end
    cur_dur_q   <= dur_mem[raddr_cur_i];
    nxt_out_q   <= out_mem[raddr_nxt_i];
    first_out_q <= out_mem['0];
    wdur_q      <= wdur_i;
    wout_q      <= wout_i;
  end

  // forward a write that lands on an entry read in the same cycle
  always_comb begin
    fwd_cur_d   = we_i && (waddr_i == raddr_cur_i);
    fwd_nxt_d   = we_i && (waddr_i == raddr_nxt_i);
    fwd_first_d = we_i && (waddr_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_cur_q   <= 1'b0;
      fwd_nxt_q   <= 1'b0;
      fwd_first_q <= 1'b0;
    end else begin
      fwd_cur_q   <= fwd_cur_d;
      fwd_nxt_q   <= fwd_nxt_d;
      fwd_first_q <= fwd_first_d;
    end
  end

  assign cur_dur_o   = fwd_cur_q ? wdur_q : cur_dur_q;
  assign nxt_out_o   = fwd_nxt_q ? wout_q : nxt_out_q;
  assign first_out_o = fwd_first_q ? wout_q : first_out_q;

endmodule

/* src/timed_pattern_sequencer.sv */
// The result is registered and valid in the cycle after the input transfer; one result per input item.
// Throughput: one item per cycle; a new item enters in the cycle the previous result
// transfers, and a stalled result holds the input.
// The step table is read ahead at the next-state position, so each item
// sees current table data; a load is forwarded to a read of the same entry.
// Reset: asynchronous active low; idle and finished, drive off, step table unset.
module timed_pattern_sequencer #(
  parameter int unsigned MAX_STEPS     = 16,
  parameter int unsigned DURATION_BITS = 16,
  parameter int unsigned OUTPUT_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic [tps_pkg::SlotFieldW-1:0]      step_slot_i,
  input  logic [DURATION_BITS-1:0]            step_duration_i,
  input  logic [OUTPUT_BITS-1:0]              step_output_i,
  input  logic [tps_pkg::LenFieldW-1:0]       play_length_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [OUTPUT_BITS-1:0]              drive_value_o,
  output logic                                drive_active_o,
  output logic                                is_playing_o,
  output logic                                is_finished_o,
  output logic [tps_pkg::StepFieldW-1:0]      current_step_o,
  output logic [tps_pkg::RemainFieldW-1:0]    steps_remaining_o
);

  import tps_pkg::*;

  localparam int unsigned IdxW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned LenW = $clog2(MAX_STEPS + 1);

  mode_e mode;
  logic  in_xfer;

  logic [LenW-1:0]          len_q, len_d;
  logic [LenW-1:0]          pos_q, pos_d;
  logic [DURATION_BITS-1:0] elapsed_q, elapsed_d;
  logic                     running_q, running_d;
  logic                     done_q, done_d;
  logic [OUTPUT_BITS-1:0]   applied_q, applied_d;
  logic                     applied_flag_q, applied_flag_d;

  logic                     out_valid_q, out_valid_d;
  logic [OUTPUT_BITS-1:0]   res_value_q;
  logic                     res_active_q, res_playing_q, res_finished_q;
  logic [StepFieldW-1:0]    res_step_q, res_step_d;
  logic [RemainFieldW-1:0]  res_remain_q, res_remain_d;

  logic                     tbl_we;
  logic [IdxW-1:0]          tbl_waddr;
  logic [DURATION_BITS-1:0] cur_dur;
  logic [OUTPUT_BITS-1:0]   nxt_out;
  logic [OUTPUT_BITS-1:0]   first_out;
  logic [LenW-1:0]          pos_nxt;

  logic [DURATION_BITS-1:0] elapsed_inc;
  logic [LenW-1:0]          pos_inc;
  logic [LenW-1:0]          len_sat;
  logic [LenW-1:0]          remain;
  logic [31:0]              slot_wide;
  logic [31:0]              pos_wide;
  logic [31:0]              remain_wide;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign slot_wide = 32'(step_slot_i);
  assign tbl_waddr = slot_wide[IdxW-1:0];

  always_comb begin
    len_d          = len_q;
    pos_d          = pos_q;
    elapsed_d      = elapsed_q;
    running_d      = running_q;
    done_d         = done_q;
    applied_d      = applied_q;
    applied_flag_d = applied_flag_q;
    tbl_we         = 1'b0;
    elapsed_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    pos_inc        = pos_q + 1'b1;
    len_sat        = (32'(play_length_i) > 32'(MAX_STEPS)) ? LenW'(MAX_STEPS)
                                                          : LenW'(play_length_i);
    if (in_xfer) begin
      unique case (mode)
        ModeTick: begin
          if (running_q) begin
            if (elapsed_inc < cur_dur) begin
              elapsed_d = elapsed_inc;
            end else if (pos_inc >= len_q) begin
              applied_d      = '0;
              applied_flag_d = 1'b0;
              len_d          = '0;
              pos_d          = '0;
              elapsed_d      = '0;
              running_d      = 1'b0;
              done_d         = 1'b1;
            end else begin
              pos_d          = pos_inc;
              elapsed_d      = '0;
              applied_d      = nxt_out;
              applied_flag_d = 1'b1;
            end
          end
        end
        ModeLoad: begin
          tbl_we = slot_wide < 32'(MAX_STEPS);
        end
        ModePlay: begin
          if (running_q) begin
            applied_d      = '0;
            applied_flag_d = 1'b0;
          end
          len_d     = '0;
          pos_d     = '0;
          elapsed_d = '0;
          running_d = 1'b0;
          done_d    = 1'b1;
          if (len_sat != '0) begin
            len_d          = len_sat;
            running_d      = 1'b1;
            done_d         = 1'b0;
            applied_d      = first_out;
            applied_flag_d = 1'b1;
          end
        end
        ModeStop: begin
          if (running_q) begin
            applied_d      = '0;
            applied_flag_d = 1'b0;
          end
          len_d     = '0;
          pos_d     = '0;
          elapsed_d = '0;
          running_d = 1'b0;
          done_d    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign pos_nxt = pos_d + 1'b1;

  tps_table #(
    .IDX_W (IdxW),
    .DUR_W (DURATION_BITS),
    .OUT_W (OUTPUT_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (tbl_we),
    .waddr_i     (tbl_waddr),
    .wdur_i      (step_duration_i),
    .wout_i      (step_output_i),
    .raddr_cur_i (pos_d[IdxW-1:0]),
    .raddr_nxt_i (pos_nxt[IdxW-1:0]),
    .cur_dur_o   (cur_dur),
    .nxt_out_o   (nxt_out),
    .first_out_o (first_out)
  );

  always_comb begin
    remain       = len_d - pos_d;
    pos_wide     = 32'(pos_d);
    remain_wide  = 32'(remain);
    res_step_d   = running_d ? pos_wide[StepFieldW-1:0] : '0;
    res_remain_d = (running_d && (len_d > pos_d)) ? remain_wide[RemainFieldW-1:0] : '0;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q          <= '0;
      pos_q          <= '0;
      elapsed_q      <= '0;
      running_q      <= 1'b0;
      done_q         <= 1'b1;
      applied_q      <= '0;
      applied_flag_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      len_q          <= len_d;
      pos_q          <= pos_d;
      elapsed_q      <= elapsed_d;
      running_q      <= running_d;
      done_q         <= done_d;
      applied_q      <= applied_d;
      applied_flag_q <= applied_flag_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_value_q    <= applied_d;
      res_active_q   <= applied_flag_d;
      res_playing_q  <= running_d;
      res_finished_q <= done_d;
      res_step_q     <= res_step_d;
      res_remain_q   <= res_remain_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_value_o     = res_value_q;
  assign drive_active_o    = res_active_q;
  assign is_playing_o      = res_playing_q;
  assign is_finished_o     = res_finished_q;
  assign current_step_o    = res_step_q;
  assign steps_remaining_o = res_remain_q;

`ifndef NO_ASSERTIONS
  a_drive_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    applied_flag_q |-> running_q)
    else $error("drive active while not running");

  a_run_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q != done_q)
    else $error("running and finished flags disagree");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (pos_q < len_q))
    else $error("step position beyond pattern length");

  a_stop_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (mode == ModeStop)) |=> (res_finished_q && !res_playing_q && !res_active_q))
    else $error("stop transfer did not finish the pattern");
`endif

endmodule
